@@ rtl/sida_pkg.sv @@
// Shared types and constants of the signed integer to decimal ASCII converter.
// No dependencies; used by every module in rtl/.
package sida_pkg;

  // Value width and decimal digits needed for a 32-bit magnitude
  localparam int VALUE_W       = 32;
  localparam int NUM_DIGITS    = 10;
  localparam int DIGIT_W       = 4;
  localparam int COUNT_W       = 4;

  // Binary to BCD conversion: bits shifted in per cycle and conversion steps per value
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH   = 2;

  // ASCII codes
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  // One converted number, as it travels through the queue
  typedef struct packed {
    logic                                neg;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits;
    logic [COUNT_W-1:0]                  ndig;
  } dec_rec_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/sida_front.sv @@
// Front part: accepts a value, splits sign and magnitude, converts to BCD.
// Depends on sida_pkg; pushes one dec_rec_t per value into sida_queue.
module sida_front import sida_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [VALUE_W-1:0] value_i,
  input  q_stat_t                   q_stat_i,
  output logic                      push_o,
  output dec_rec_t                  push_rec_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;
  localparam int STEP_W = (CONV_STEPS > 1) ? $clog2(CONV_STEPS) : 1;
  localparam int BCD_W  = NUM_DIGITS * DIGIT_W;

  logic [1:0]         state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [VALUE_W-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic               neg_q, neg_d;

  logic [VALUE_W-1:0] raw;
  logic [VALUE_W-1:0] mag_nx;
  logic [BCD_W-1:0]   bcd_nx;
  logic [COUNT_W-1:0] ndig;
  logic               accept;

  assign raw        = VALUE_W'(value_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Shift in several magnitude bits, adding three to each digit above four
  always_comb begin
    bcd_nx = bcd_q;
    mag_nx = mag_q;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_nx[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
          bcd_nx[d*DIGIT_W +: DIGIT_W] = bcd_nx[d*DIGIT_W +: DIGIT_W] + 4'd3;
        end
      end
      bcd_nx = {bcd_nx[BCD_W-2:0], mag_nx[VALUE_W-1]};
      mag_nx = {mag_nx[VALUE_W-2:0], 1'b0};
    end
  end

  // Count significant digits, at least one
  always_comb begin
    ndig = COUNT_W'(1);
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_q[d*DIGIT_W +: DIGIT_W] != '0) begin
        ndig = COUNT_W'(d + 1);
      end
    end
  end

  // Sequence accept, conversion and push
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    push_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          neg_d   = raw[VALUE_W-1];
          mag_d   = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
          bcd_d   = '0;
          step_d  = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        mag_d  = mag_nx;
        bcd_d  = bcd_nx;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(CONV_STEPS - 1)) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!q_stat_i.full) begin
          push_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign push_rec_o.neg    = neg_q;
  assign push_rec_o.digits = bcd_q;
  assign push_rec_o.ndig   = ndig;

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

endmodule

@@ rtl/sida_queue.sv @@
// Short queue of converted numbers between front and back.
// Depends on sida_pkg for dec_rec_t and q_stat_t.
module sida_queue import sida_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  dec_rec_t push_rec_i,
  input  logic     pop_i,
  output dec_rec_t pop_rec_o,
  output q_stat_t  q_stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  dec_rec_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign q_stat_o.full  = (cnt_q == CntW'(Depth));
  assign q_stat_o.empty = (cnt_q == '0);
  assign pop_rec_o      = mem_q[rd_ptr_q];

  // Write the pushed record
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ rtl/sida_back.sv @@
// Back part: takes a converted number from the queue and sends its characters.
// Depends on sida_pkg; one character transfer per cycle on the output channel while it is not stalled.
module sida_back import sida_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  q_stat_t            q_stat_i,
  input  dec_rec_t           pop_rec_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_char_o,
  output logic               is_last_o,
  output logic [COUNT_W-1:0] char_count_o
);

  logic                               active_q;
  logic                               sign_q;
  logic [COUNT_W-1:0]                 rem_q;
  logic [COUNT_W-1:0]                 total_q;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_q;

  logic               xfer;
  logic               last;
  logic [COUNT_W-1:0] idx;
  logic [DIGIT_W-1:0] dig;

  assign xfer = active_q && !out_stall_i;
  assign last = !sign_q && (rem_q == COUNT_W'(1));
  assign pop_o = (!active_q || (xfer && last)) && !q_stat_i.empty;

  // Select the digit due next: remaining count minus one
  assign idx = rem_q - COUNT_W'(1);
  always_comb begin
    dig = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (idx == COUNT_W'(d)) begin
        dig = digits_q[d];
      end
    end
  end

  assign out_valid_o  = active_q;
  assign out_char_o   = sign_q ? ASCII_MINUS : (ASCII_ZERO + {4'b0000, dig});
  assign is_last_o    = last;
  assign char_count_o = last ? total_q : '0;

  // Load a record on pop, step through its characters on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      sign_q   <= 1'b0;
      rem_q    <= '0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
        sign_q   <= pop_rec_i.neg;
        rem_q    <= pop_rec_i.ndig;
      end else if (xfer) begin
        if (last) begin
          active_q <= 1'b0;
        end else if (sign_q) begin
          sign_q <= 1'b0;
        end else begin
          rem_q <= rem_q - COUNT_W'(1);
        end
      end
    end
  end

  // Payload of the current number
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      digits_q <= pop_rec_i.digits;
      total_q  <= pop_rec_i.ndig + {{(COUNT_W-1){1'b0}}, pop_rec_i.neg};
    end
  end

endmodule

@@ rtl/signed_int_to_decimal_ascii_top.sv @@
// Top level of the signed integer to decimal ASCII converter.
// Depends on sida_pkg, sida_front, sida_queue and sida_back.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | value_i (32 bit signed)
//   out     | output    | out_valid_o / out_stall_i | out_char_o, is_last_o, char_count_o
//
// The front takes a value, converts it to BCD in ST_CONV (four bits a cycle)
// and pushes it in ST_PUSH; it takes no new value until it is back in idle.
// The back sends one character per cycle while the output is not stalled,
// and takes the next number from the queue with the last character's transfer.
// Reset clears control state only; nothing is kept between values.
// A stall on the output holds the current character; the queue lets the front
// keep converting until it fills.
module signed_int_to_decimal_ascii_top import sida_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                out_char_o,
  output logic                      is_last_o,
  output logic [COUNT_W-1:0]        char_count_o
);

  q_stat_t  q_stat;
  logic     push;
  logic     pop;
  dec_rec_t push_rec;
  dec_rec_t pop_rec;

  sida_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_rec_o (push_rec)
  );

  sida_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .pop_rec_o  (pop_rec),
    .q_stat_o   (q_stat)
  );

  sida_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .pop_rec_i    (pop_rec),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .is_last_o    (is_last_o),
    .char_count_o (char_count_o)
  );

endmodule
